[design/oaee_pkg.sv]
// ----------------------------------------------------------------------------
// oaee_pkg
// Shared types and constants for the ordered array edit engine: command and
// status codes, the cell step modes and the control word sent along the row.
// ----------------------------------------------------------------------------
package oaee_pkg;

    localparam int WORD_W      = 32;
    localparam int SLOT_W      = 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int INDEX_W     = 7;
    localparam int COUNT_W     = 8;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 56;
    localparam int M_PAYLOAD_W = STATUS_W + WORD_W + INDEX_W + COUNT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_READ    = 2'd2,
        CMD_REVERSE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_BADPOS = 3'd1,
        STAT_EMPTY  = 3'd2,
        STAT_NOKEY  = 3'd3,
        STAT_FULL   = 3'd4
    } status_t;

    // Step applied by all cells in the same cycle.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_ROT  = 2'd1,
        CELL_DROP = 2'd2,
        CELL_INS  = 2'd3
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t                mode;
        logic signed [WORD_W-1:0]  data;
    } cell_ctrl_t;

endpackage

[design/ordered_array_edit_engine_unit.sv]
// ----------------------------------------------------------------------------
// ordered_array_edit_engine_unit
// Ordered list of signed 32-bit words kept in a row of cells, with insert at
// a position, delete of the first matching key, read at a position and
// reverse. One result word per command word.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  s_        in         tuser: command; tdata: operand_value, slot
//  m_        out        tdata: status, read_data, found_index, count_after
//
// An error result goes from idle straight to the finish state, an insert
// passes through the insert state first, and a read, delete or reverse
// walks all stored words through the head cell in the scan state, one
// rotation step of the row per cycle.
// Reset clears the count and the control state; cell contents are not reset.
// A finished result waits in the output register while the next command word
// is already accepted; the engine stalls only when a second result is ready.
// ----------------------------------------------------------------------------
module ordered_array_edit_engine_unit #(
    parameter int CAPACITY = 128
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [oaee_pkg::CMD_W-1:0]          s_tuser,  // command
    input  logic [oaee_pkg::S_TDATA_W-1:0]      s_tdata,  // operand_value, slot
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status, read_data, found_index, count_after
    output logic [oaee_pkg::M_TDATA_W-1:0]      m_tdata
);
    import oaee_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_FIN
    } state_t;

    state_t                    state_reg;
    cmd_t                      cmd_reg;
    logic signed [WORD_W-1:0]  key_reg;
    logic [CW-1:0]             slot_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             bound_reg;
    logic [CW-1:0]             step_reg;
    logic [CW-1:0]             hit_reg;
    logic                      found_reg;
    status_t                   status_reg;
    logic signed [WORD_W-1:0]  rdata_reg;

    logic                      m_tvalid_reg;
    status_t                   m_status_reg;
    logic signed [WORD_W-1:0]  m_rdata_reg;
    logic [INDEX_W-1:0]        m_index_reg;
    logic [COUNT_W-1:0]        m_count_reg;

    cmd_t                      in_cmd;
    logic signed [WORD_W-1:0]  in_value;
    logic [SLOT_W-1:0]         in_slot;
    logic [CMPW-1:0]           slot_ext;
    logic [CMPW-1:0]           count_ext;
    logic [CMPW-1:0]           hit_ext;
    status_t                   in_status;
    state_t                    in_state;
    cell_ctrl_t                cell_ctrl;
    logic signed [WORD_W-1:0]  head;
    logic                      drop_now;
    logic                      last_step;
    logic                      out_free;

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_value  = s_tdata[WORD_W-1:0];
    assign in_slot   = s_tdata[WORD_W+SLOT_W-1:WORD_W];
    assign slot_ext  = CMPW'(in_slot);
    assign count_ext = CMPW'(count_reg);
    assign hit_ext   = CMPW'(hit_reg);

    assign drop_now  = (state_reg == S_SCAN) && (cmd_reg == CMD_DELETE) &&
                       !found_reg && (head == key_reg);
    assign last_step = (step_reg == count_reg - 1'b1);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        in_status = STAT_OK;
        in_state  = S_FIN;
        case (in_cmd)
            CMD_INSERT: begin
                if (slot_ext > count_ext) begin
                    in_status = STAT_BADPOS;
                end else if (count_reg == CW'(CAPACITY)) begin
                    in_status = STAT_FULL;
                end else begin
                    in_state = S_INS;
                end
            end
            CMD_READ: begin
                if (count_reg == '0) begin
                    in_status = STAT_EMPTY;
                end else if (slot_ext >= count_ext) begin
                    in_status = STAT_BADPOS;
                end else begin
                    in_state = S_SCAN;
                end
            end
            default: begin
                if (count_reg == '0) begin
                    in_status = STAT_EMPTY;
                end else begin
                    in_state = S_SCAN;
                end
            end
        endcase
    end

    always_comb begin
        cell_ctrl.mode = CELL_HOLD;
        cell_ctrl.data = key_reg;
        case (state_reg)
            S_INS: begin
                cell_ctrl.mode = CELL_INS;
            end
            S_SCAN: begin
                cell_ctrl.mode = drop_now ? CELL_DROP : CELL_ROT;
            end
            default: begin
                cell_ctrl.mode = CELL_HOLD;
            end
        endcase
    end

    oaee_row #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_row (
        .aclk  (aclk),
        .ctrl  (cell_ctrl),
        .bound (bound_reg),
        .pos   (slot_reg),
        .head  (head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg    <= in_cmd;
                        key_reg    <= in_value;
                        slot_reg   <= slot_ext[CW-1:0];
                        bound_reg  <= count_reg;
                        step_reg   <= '0;
                        hit_reg    <= '0;
                        found_reg  <= 1'b0;
                        rdata_reg  <= '0;
                        status_reg <= in_status;
                        state_reg  <= in_state;
                    end
                end
                S_INS: begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_FIN;
                end
                S_SCAN: begin
                    step_reg <= step_reg + 1'b1;
                    if ((cmd_reg == CMD_READ) && (step_reg == slot_reg)) begin
                        rdata_reg <= head;
                    end
                    if (drop_now) begin
                        found_reg <= 1'b1;
                        hit_reg   <= step_reg;
                        bound_reg <= bound_reg - 1'b1;
                    end
                    if (cmd_reg == CMD_REVERSE) begin
                        bound_reg <= bound_reg - 1'b1;
                    end
                    if (last_step) begin
                        state_reg <= S_FIN;
                        if (cmd_reg == CMD_DELETE) begin
                            if (found_reg || drop_now) begin
                                count_reg <= count_reg - 1'b1;
                            end else begin
                                status_reg <= STAT_NOKEY;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= status_reg;
                        m_rdata_reg  <= rdata_reg;
                        m_index_reg  <= hit_ext[INDEX_W-1:0];
                        m_count_reg  <= count_ext[COUNT_W-1:0];
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_PAYLOAD_W){1'b0}}, m_count_reg, m_index_reg,
                       m_rdata_reg, m_status_reg};

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("stored word count exceeds capacity");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command word accepted while another is in progress");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> step_reg < count_reg)
        else $error("scan step ran past the stored words");

    a_reverse_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN && cmd_reg == CMD_REVERSE |->
            ({1'b0, bound_reg} + {1'b0, step_reg}) == {1'b0, count_reg})
        else $error("reverse ring bound out of step with the scan");

endmodule

[design/oaee_cell.sv]
// ----------------------------------------------------------------------------
// oaee_cell
// One storage cell of the list. Depending on the broadcast step it holds its
// word, takes its right or left neighbor, takes the head word, or loads the
// inserted value.
// ----------------------------------------------------------------------------
module oaee_cell #(
    parameter int IDX = 0,
    parameter int CW  = 8
) (
    input  logic                                aclk,
    input  oaee_pkg::cell_ctrl_t                ctrl,
    input  logic [CW-1:0]                       bound,
    input  logic [CW-1:0]                       pos,
    input  logic signed [oaee_pkg::WORD_W-1:0]  left,
    input  logic signed [oaee_pkg::WORD_W-1:0]  right,
    input  logic signed [oaee_pkg::WORD_W-1:0]  wrap,
    output logic signed [oaee_pkg::WORD_W-1:0]  word_out
);
    import oaee_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic [CW-1:0]            here;
    logic [CW-1:0]            here_plus;

    assign here      = CW'(IDX);
    assign here_plus = CW'(IDX + 1);

    always_comb begin
        word_next = word_reg;
        case (ctrl.mode)
            CELL_ROT: begin
                if (here_plus < bound) begin
                    word_next = right;
                end else if (here_plus == bound) begin
                    word_next = wrap;
                end
            end
            CELL_DROP: begin
                if (here_plus < bound) begin
                    word_next = right;
                end
            end
            CELL_INS: begin
                if (here > pos) begin
                    word_next = left;
                end else if (here == pos) begin
                    word_next = ctrl.data;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule

[design/oaee_row.sv]
// ----------------------------------------------------------------------------
// oaee_row
// The row of cells that holds the list. Each cell talks only to its two
// neighbors; the head cell's word is fed back to the cells as the wrap input
// and is the only word brought out.
// ----------------------------------------------------------------------------
module oaee_row #(
    parameter int CAPACITY = 128,
    parameter int CW       = 8
) (
    input  logic                                aclk,
    input  oaee_pkg::cell_ctrl_t                ctrl,
    input  logic [CW-1:0]                       bound,
    input  logic [CW-1:0]                       pos,
    output logic signed [oaee_pkg::WORD_W-1:0]  head
);
    import oaee_pkg::*;

    logic signed [WORD_W-1:0] words [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = words[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = words[i+1];
        end

        oaee_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .bound    (bound),
            .pos      (pos),
            .left     (left_w),
            .right    (right_w),
            .wrap     (words[0]),
            .word_out (words[i])
        );
    end

    assign head = words[0];

endmodule
